/* rtl/pli_pkg.sv */
// ----------------------------------------------------------------------------
// pli_pkg: shared types and constants
// Field widths, operation codes, result status codes and the per-cell
// command word of the positional list.
// ----------------------------------------------------------------------------
package pli_pkg;

	localparam int FUNC_W  = 3;
	localparam int POS_W   = 8;
	localparam int VALUE_W = 32;
	localparam int ELEM_W  = 32;
	localparam int STAT_W  = 2;
	localparam int LEN_W   = 5;

	typedef enum logic [FUNC_W-1:0] {
		F_INS_FIRST = 3'd0,
		F_INS_LAST  = 3'd1,
		F_INS_AT    = 3'd2,
		F_DEL_FIRST = 3'd3,
		F_DEL_LAST  = 3'd4,
		F_DEL_AT    = 3'd5,
		F_DUMP      = 3'd6
	} func_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK     = 2'd0,
		STAT_BADPOS = 2'd1,
		STAT_FULL   = 2'd2,
		STAT_EMPTY  = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_INSERT,
		CELL_DELETE,
		CELL_ROTATE
	} cell_op_t;

	// Broadcast to every cell; each cell compares against its own index.
	typedef struct packed {
		cell_op_t         op;
		logic [POS_W-1:0] pos;
		logic [POS_W-1:0] top;
	} cell_ctl_t;

	typedef enum logic {
		S_IDLE,
		S_DUMP
	} state_t;

endpackage

/* rtl/pli_cmd_if.sv */
// ----------------------------------------------------------------------------
// pli_cmd_if: command channel
// Valid/ready channel carrying one list operation per word.
// ----------------------------------------------------------------------------
interface pli_cmd_if;
	import pli_pkg::*;

	logic               valid;
	logic               ready;
	logic [FUNC_W-1:0]  func;
	logic [POS_W-1:0]   position;
	logic [VALUE_W-1:0] value;

	modport source (output valid, func, position, value, input ready);
	modport sink   (input valid, func, position, value, output ready);

endinterface

/* rtl/pli_rsp_if.sv */
// ----------------------------------------------------------------------------
// pli_rsp_if: result channel
// Valid/ready channel carrying one result word.
// ----------------------------------------------------------------------------
interface pli_rsp_if;
	import pli_pkg::*;

	logic              valid;
	logic              ready;
	logic [ELEM_W-1:0] element;
	logic [STAT_W-1:0] status;
	logic [LEN_W-1:0]  length;
	logic              last;

	modport source (output valid, element, status, length, last, input ready);
	modport sink   (input valid, element, status, length, last, output ready);

endinterface

/* rtl/pli_cell.sv */
// ----------------------------------------------------------------------------
// pli_cell: one storage cell of the list chain
// Holds one data word and, on command, takes the word of its left or right
// neighbor, the wrap word from the head, or the new value.
// ----------------------------------------------------------------------------
module pli_cell #(
	parameter int DATA_WIDTH = 32,
	parameter int INDEX      = 0
) (
	input  logic                  clk,
	input  pli_pkg::cell_ctl_t    ctl,
	input  logic [DATA_WIDTH-1:0] value,
	input  logic [DATA_WIDTH-1:0] left,
	input  logic [DATA_WIDTH-1:0] right,
	input  logic [DATA_WIDTH-1:0] wrap,
	output logic [DATA_WIDTH-1:0] data
);
	import pli_pkg::*;

	localparam logic [POS_W-1:0] IDX = POS_W'(INDEX);

	logic [DATA_WIDTH-1:0] data_q;
	logic [DATA_WIDTH-1:0] data_d;

	always_comb begin
		data_d = data_q;
		case (ctl.op)
			CELL_INSERT: begin
				if (IDX > ctl.pos) begin
					data_d = left;
				end else if (IDX == ctl.pos) begin
					data_d = value;
				end
			end
			CELL_DELETE: begin
				if (IDX >= ctl.pos) begin
					data_d = right;
				end
			end
			CELL_ROTATE: begin
				// tail of the occupied run takes the head word
				if (IDX == ctl.top) begin
					data_d = wrap;
				end else if (IDX < ctl.top) begin
					data_d = right;
				end
			end
			default: begin
				data_d = data_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		data_q <= data_d;
	end

	assign data = data_q;

endmodule

/* rtl/positional_list_insert_delete.sv */
// ----------------------------------------------------------------------------
// positional_list_insert_delete: bounded ordered list in a chain of cells
// Insert and delete at head, tail or a 1-based position; dump in order.
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake    | payload
//  --------+-----+--------------+-------------------------------------
//  cmd     | in  | valid/ready  | func, position, value
//  rsp     | out | valid/ready  | element, status, length, last
//
// For insert, delete and rejected operations the result sits in the output
// register the cycle after the command word is taken.
// Dump emits the stored words in turn: the chain rotates one place a cycle
// unless the result is stalled, and the head cell feeds the output, so the order is restored at the end.
// Reset clears the word count, the sequencer and the output valid; cell
// contents are not reset. A stalled result holds the chain and the sequencer.
// ----------------------------------------------------------------------------
module positional_list_insert_delete #(
	parameter int DEPTH      = 16,
	parameter int DATA_WIDTH = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	pli_cmd_if.sink   cmd,
	pli_rsp_if.source rsp
);
	import pli_pkg::*;

	localparam int CW = $clog2(DEPTH + 1);

	state_t  state_q, state_d;
	logic [CW-1:0] count_q, count_d;
	logic [CW-1:0] rem_q, rem_d;

	logic              valid_q;
	logic [ELEM_W-1:0] element_q, element_d;
	logic [STAT_W-1:0] status_q, status_d;
	logic [LEN_W-1:0]  length_q;
	logic              last_q, last_d;
	logic              load_out;

	logic      adv;
	logic      accept;
	cell_ctl_t ctl;

	logic [POS_W:0]   pos9;
	logic [POS_W:0]   cnt9;
	logic [POS_W-1:0] top_idx;
	logic             full;

	logic [DATA_WIDTH-1:0] value_w;
	logic [DATA_WIDTH-1:0] cell_data [DEPTH];

	assign adv     = !valid_q || rsp.ready;
	assign accept  = cmd.valid && cmd.ready;
	assign pos9    = {1'b0, cmd.position};
	assign cnt9    = (POS_W + 1)'(count_q);
	assign top_idx = POS_W'(count_q) - POS_W'(1);
	assign full    = (count_q >= CW'(DEPTH));
	assign value_w = DATA_WIDTH'(cmd.value);

	always_comb begin
		cmd.ready = (state_q == S_IDLE) && adv;
		state_d   = state_q;
		count_d   = count_q;
		rem_d     = rem_q;
		ctl.op    = CELL_HOLD;
		ctl.pos   = '0;
		ctl.top   = top_idx;
		load_out  = 1'b0;
		element_d = '0;
		status_d  = STAT_OK;
		last_d    = 1'b1;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					load_out = 1'b1;
					case (func_t'(cmd.func))
						F_INS_FIRST, F_INS_LAST, F_INS_AT: begin
							if (func_t'(cmd.func) == F_INS_AT &&
							    (pos9 == '0 || pos9 > cnt9 + (POS_W + 1)'(1))) begin
								status_d = STAT_BADPOS;
							end else if (full) begin
								status_d = STAT_FULL;
							end else begin
								ctl.op = CELL_INSERT;
								if (func_t'(cmd.func) == F_INS_FIRST) begin
									ctl.pos = '0;
								end else if (func_t'(cmd.func) == F_INS_LAST) begin
									ctl.pos = POS_W'(count_q);
								end else begin
									ctl.pos = cmd.position - POS_W'(1);
								end
								count_d = count_q + CW'(1);
							end
						end
						F_DEL_FIRST, F_DEL_LAST: begin
							if (count_q == '0) begin
								status_d = STAT_BADPOS;
							end else begin
								ctl.op  = CELL_DELETE;
								ctl.pos = (func_t'(cmd.func) == F_DEL_FIRST) ? '0 : top_idx;
								count_d = count_q - CW'(1);
							end
						end
						F_DEL_AT: begin
							if (pos9 == '0 || pos9 > cnt9) begin
								status_d = STAT_BADPOS;
							end else begin
								ctl.op  = CELL_DELETE;
								ctl.pos = cmd.position - POS_W'(1);
								count_d = count_q - CW'(1);
							end
						end
						F_DUMP: begin
							if (count_q == '0) begin
								status_d = STAT_EMPTY;
							end else begin
								// emit the head now, rotate the rest out one a cycle while the result is not stalled
								element_d = ELEM_W'(cell_data[0]);
								ctl.op    = CELL_ROTATE;
								last_d    = (count_q == CW'(1));
								rem_d     = count_q - CW'(1);
								if (count_q != CW'(1)) begin
									state_d = S_DUMP;
								end
							end
						end
						default: begin
							status_d = STAT_OK;
						end
					endcase
				end
			end
			S_DUMP: begin
				if (adv) begin
					load_out  = 1'b1;
					element_d = ELEM_W'(cell_data[0]);
					ctl.op    = CELL_ROTATE;
					last_d    = (rem_q == CW'(1));
					rem_d     = rem_q - CW'(1);
					if (rem_q == CW'(1)) begin
						state_d = S_IDLE;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			rem_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			rem_q   <= rem_d;
			if (load_out) begin
				valid_q <= 1'b1;
			end else if (rsp.ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			element_q <= element_d;
			status_q  <= status_d;
			length_q  <= LEN_W'(count_d);
			last_q    <= last_d;
		end
	end

	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		logic [DATA_WIDTH-1:0] left_w;
		logic [DATA_WIDTH-1:0] right_w;

		if (g == 0) begin : g_head
			assign left_w = '0;
		end else begin : g_body
			assign left_w = cell_data[g-1];
		end

		if (g == DEPTH - 1) begin : g_tail
			assign right_w = '0;
		end else begin : g_next
			assign right_w = cell_data[g+1];
		end

		pli_cell #(
			.DATA_WIDTH (DATA_WIDTH),
			.INDEX      (g)
		) u_cell (
			.clk   (clk),
			.ctl   (ctl),
			.value (value_w),
			.left  (left_w),
			.right (right_w),
			.wrap  (cell_data[0]),
			.data  (cell_data[g])
		);
	end

	assign rsp.valid   = valid_q;
	assign rsp.element = element_q;
	assign rsp.status  = status_q;
	assign rsp.length  = length_q;
	assign rsp.last    = last_q;

endmodule

/* rtl/pli_checker.sv */
// ----------------------------------------------------------------------------
// pli_checker: port-level checks of the positional list
// Watches the result channel and flags results that break the list rules.
// ----------------------------------------------------------------------------
module pli_checker #(
	parameter int DEPTH = 16
) (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       rsp_valid,
	input logic                       rsp_ready,
	input logic [pli_pkg::ELEM_W-1:0] rsp_element,
	input logic [pli_pkg::STAT_W-1:0] rsp_status,
	input logic [pli_pkg::LEN_W-1:0]  rsp_length,
	input logic                       rsp_last
);
	import pli_pkg::*;

	// hold a stalled result word
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("result word dropped while stalled");

	// an empty dump reports a zero length and a lone zero word
	a_empty_dump: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status == STAT_EMPTY |->
			rsp_length == '0 && rsp_last && rsp_element == '0)
		else $error("empty dump result malformed");

	// only a dump gives several words, and those are all ok
	a_multi_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_last |-> rsp_status == STAT_OK)
		else $error("non-final word with error status");

	// a rejected operation gives a single zero word
	a_reject: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_status == STAT_BADPOS || rsp_status == STAT_FULL) |->
			rsp_last && rsp_element == '0)
		else $error("rejected operation result malformed");

	a_length: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> int'(rsp_length) <= DEPTH)
		else $error("length beyond store depth");

endmodule

bind positional_list_insert_delete pli_checker #(
	.DEPTH (DEPTH)
) u_pli_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.rsp_valid   (rsp.valid),
	.rsp_ready   (rsp.ready),
	.rsp_element (rsp.element),
	.rsp_status  (rsp.status),
	.rsp_length  (rsp.length),
	.rsp_last    (rsp.last)
);
